FILE: rtl/core/lrls_pkg.sv
`default_nettype none

package lrls_pkg;

    localparam int LEVELS   = 256;
    localparam int CHANNELS = 4;
    localparam int PWM_BITS = 16;

    localparam int LVL_AW = $clog2(LEVELS);
    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] FUNC_LOAD      = 2'd0;
    localparam logic [1:0] FUNC_SET_LEVEL = 2'd1;
    localparam logic [1:0] FUNC_SET_GOAL  = 2'd2;
    localparam logic [1:0] FUNC_TICK      = 2'd3;

    localparam logic [1:0] CFG_EN_LOW  = 2'd0;
    localparam logic [1:0] CFG_EN_HIGH = 2'd1;
    localparam logic [1:0] CFG_FULL_ON = 2'd2;

    typedef logic [PWM_BITS-1:0] t_pwm;
    typedef logic [CHANNELS-1:0][PWM_BITS-1:0] t_pwm_row;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  level;
        logic [1:0]  channel;
        logic [15:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_ch0;
        logic [15:0] pwm_ch1;
        logic [15:0] pwm_ch2;
        logic [15:0] pwm_ch3;
        logic [7:0]  current_level;
        logic        power_enable;
        logic        phase_reset;
    } t_out_item;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] level;
    } t_op;

    typedef struct packed {
        t_pwm_row   pwm;
        logic [7:0] reached;
        logic       enable;
        logic       was_on;
    } t_state;

    typedef struct packed {
        logic [7:0] en_low;
        logic [7:0] en_high;
        t_pwm       full_on;
    } t_cfg;

    function automatic logic [15:0] pwm_lane(input t_pwm_row row, input int idx);
        logic [15:0] v;
        v = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c == idx) begin
                v = 16'(row[c]);
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/led_ramp_level_slewer.sv
// Multi-channel LED brightness ramp. Load transfers fill a per-level PWM table held in
// synchronous RAM; set-level and tick transfers move the PWM outputs, the reached level
// and the power enable; set-goal transfers set the goal. Every input transfer yields
// exactly one output transfer. Items are taken one per cycle while the output is not held
// back, except that a tick directly behind a tick or a set-level waits until that item
// has left stage 1, because its stepped level needs the reached level that the earlier item
// settles only after its table read. No transfer is taken while reset is held. Configuration
// writes are taken in any cycle out of reset and must be made while the block is idle.
`default_nettype none

module led_ramp_level_slewer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire lrls_pkg::t_in_item i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lrls_pkg::t_out_item  o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [1:0]            i_cfg_index,
    input  wire [15:0]           i_cfg_data
);
    import lrls_pkg::*;

    t_cfg       r_cfg;
    logic [7:0] r_goal;
    logic       r_s1_valid;
    t_op        r_s1_op;
    logic       r_out_valid;
    t_state     r_state;
    logic       r_phase;

    t_op        n_op;
    t_state     n_state;
    logic       n_phase;
    t_pwm_row   rd_data;
    logic [7:0] sat_level;
    logic [7:0] step_level;
    logic       load_ok;
    logic       s1_go;
    logic       hazard;
    logic       in_fire;

    assign sat_level = ({1'b0, i_in.level} > 9'(LEVELS - 1)) ? 8'(LEVELS - 1) : i_in.level;

    always_comb begin
        if (r_goal < r_state.reached) begin
            step_level = r_state.reached - 8'd1;
        end else if (r_goal > r_state.reached) begin
            step_level = r_state.reached + 8'd1;
        end else begin
            step_level = r_goal;
        end
    end

    assign load_ok = (i_in.level != 8'd0) && ({1'b0, i_in.level} < 9'(LEVELS))
                     && ({1'b0, i_in.channel} < 3'(CHANNELS));

    assign n_op.func  = i_in.func;
    assign n_op.level = (i_in.func == FUNC_TICK) ? step_level : sat_level;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign hazard     = r_s1_valid && (i_in.func == FUNC_TICK)
                        && (r_s1_op.func inside {FUNC_TICK, FUNC_SET_LEVEL});
    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_go) && !hazard;
    assign in_fire    = i_in_valid && o_in_ready;

    lrls_table u_table (
        .i_clk       (i_clk),
        .i_we        (in_fire && (i_in.func == FUNC_LOAD) && load_ok),
        .i_wr_level  (i_in.level[LVL_AW-1:0]),
        .i_wr_channel(i_in.channel[CH_AW-1:0]),
        .i_wr_data   (i_in.table_value[PWM_BITS-1:0]),
        .i_re        (in_fire),
        .i_rd_level  (n_op.level[LVL_AW-1:0]),
        .o_rd_data   (rd_data)
    );

    lrls_slew u_slew (
        .i_op     (r_s1_op),
        .i_rd_data(rd_data),
        .i_cur    (r_state),
        .i_cfg    (r_cfg),
        .o_nxt    (n_state),
        .o_phase  (n_phase)
    );

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en_low  <= 8'd1;
            r_cfg.en_high <= 8'd255;
            r_cfg.full_on <= PWM_BITS'(16'd255);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EN_LOW:  r_cfg.en_low  <= i_cfg_data[7:0];
                CFG_EN_HIGH: r_cfg.en_high <= i_cfg_data[7:0];
                CFG_FULL_ON: r_cfg.full_on <= i_cfg_data[PWM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal      <= 8'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_phase     <= 1'b0;
        end else begin
            if (in_fire && (i_in.func inside {FUNC_SET_LEVEL, FUNC_SET_GOAL})) begin
                r_goal <= sat_level;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_phase     <= n_phase;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op <= n_op;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out.pwm_ch0       = pwm_lane(r_state.pwm, 0);
    assign o_out.pwm_ch1       = pwm_lane(r_state.pwm, 1);
    assign o_out.pwm_ch2       = pwm_lane(r_state.pwm, 2);
    assign o_out.pwm_ch3       = pwm_lane(r_state.pwm, 3);
    assign o_out.current_level = r_state.reached;
    assign o_out.power_enable  = r_state.enable;
    assign o_out.phase_reset   = r_phase;

    a_tick_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.func == FUNC_TICK) |->
            !(r_s1_valid && (r_s1_op.func == FUNC_TICK || r_s1_op.func == FUNC_SET_LEVEL)))
        else $error("tick accepted while reached level is still pending");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_state.reached} <= 9'(LEVELS - 1)) && ({1'b0, r_goal} <= 9'(LEVELS - 1)))
        else $error("ramp level beyond table range");

    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_op.func == FUNC_SET_LEVEL && r_s1_op.level == 8'd0) |=>
            (r_state.pwm == '0 && !r_state.enable && !r_state.was_on))
        else $error("set-level to off left outputs active");

    a_phase_turn_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && n_phase) |=> (r_state.was_on && r_phase && o_out_valid))
        else $error("phase reset without turn-on");

endmodule

`default_nettype wire

FILE: rtl/core/lrls_table.sv
`default_nettype none

module lrls_table (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [lrls_pkg::LVL_AW-1:0] i_wr_level,
    input  wire [lrls_pkg::CH_AW-1:0]  i_wr_channel,
    input  wire lrls_pkg::t_pwm       i_wr_data,
    input  wire                       i_re,
    input  wire [lrls_pkg::LVL_AW-1:0] i_rd_level,
    output lrls_pkg::t_pwm_row        o_rd_data
);
    import lrls_pkg::*;

    t_pwm_row r_rd;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic [PWM_BITS-1:0] r_mem [LEVELS];

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wr_channel == CH_AW'(c))) begin
                r_mem[i_wr_level] <= i_wr_data;
            end
            if (i_re) begin
                r_rd[c] <= r_mem[i_rd_level];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

FILE: rtl/core/lrls_slew.sv
`default_nettype none

module lrls_slew (
    input  wire lrls_pkg::t_op      i_op,
    input  wire lrls_pkg::t_pwm_row i_rd_data,
    input  wire lrls_pkg::t_state   i_cur,
    input  wire lrls_pkg::t_cfg     i_cfg,
    output lrls_pkg::t_state        o_nxt,
    output logic                    o_phase
);
    import lrls_pkg::*;

    t_pwm_row target;
    logic     in_window;
    logic     all_match;
    logic     descending;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            target[c] = (i_op.level == 8'd0) ? '0 : i_rd_data[c];
        end
        in_window  = (i_op.level >= i_cfg.en_low) && (i_op.level <= i_cfg.en_high);
        descending = (i_op.level <= i_cur.reached);
    end

    always_comb begin
        o_nxt     = i_cur;
        o_phase   = 1'b0;
        all_match = 1'b1;
        case (i_op.func)
            FUNC_SET_LEVEL: begin
                o_nxt.pwm     = target;
                o_nxt.reached = i_op.level;
                o_nxt.was_on  = (i_op.level != 8'd0);
                o_nxt.enable  = (i_op.level != 8'd0) && in_window;
                o_phase       = (i_op.level != 8'd0) && !i_cur.was_on;
            end
            FUNC_TICK: begin
                o_nxt.enable = in_window;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (c == 0 && descending && i_cur.pwm[c] == '0
                        && target[c] == i_cfg.full_on) begin
                        o_nxt.pwm[c] = target[c];
                    end else if (i_cur.pwm[c] < target[c]) begin
                        o_nxt.pwm[c] = i_cur.pwm[c] + 1'b1;
                    end else if (i_cur.pwm[c] > target[c]) begin
                        o_nxt.pwm[c] = i_cur.pwm[c] - 1'b1;
                    end
                    if (o_nxt.pwm[c] != target[c]) begin
                        all_match = 1'b0;
                    end
                end
                if (all_match) begin
                    o_nxt.reached = i_op.level;
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: verif/tb_led_ramp_level_slewer.sv
`timescale 1ns / 1ps

module tb_led_ramp_level_slewer;

    import lrls_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int PHASE_COMMANDS  = 330;

    class slew_predictor;
        logic [15:0] level_tbl [256][4];
        bit   [3:0]  written [256];
        logic [15:0] pwm [4];
        logic [7:0]  reached;
        logic [7:0]  goal;
        bit          was_on;
        bit          enable;
        logic [7:0]  en_low;
        logic [7:0]  en_high;
        logic [15:0] full_on;
        t_out_item   expected_snapshots [$];
        int errors, checked;
        int loads, set_levels, goals, ticks, ch0_snaps, phase_restarts, level_steps;

        function new();
            for (int l = 0; l < 256; l++) begin
                written[l] = '0;
            end
            for (int c = 0; c < 4; c++) begin
                pwm[c] = '0;
            end
            reached = '0;
            goal = '0;
            was_on = 1'b0;
            enable = 1'b0;
            en_low = 8'd1;
            en_high = 8'd255;
            full_on = 16'd255;
            errors = 0;
            checked = 0;
            loads = 0;
            set_levels = 0;
            goals = 0;
            ticks = 0;
            ch0_snaps = 0;
            phase_restarts = 0;
            level_steps = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_EN_LOW: en_low = data[7:0];
                CFG_EN_HIGH: en_high = data[7:0];
                CFG_FULL_ON: full_on = data;
                default: ;
            endcase
        endfunction

        function bit level_ready(int lv);
            return lv == 0 || written[lv] == 4'hF;
        endfunction

        function bit in_band(logic [7:0] lv);
            return lv >= en_low && lv <= en_high;
        endfunction

        function logic [15:0] level_pwm(logic [7:0] lv, int c);
            return (lv == 0) ? 16'd0 : level_tbl[lv][c];
        endfunction

        function void apply_command(t_in_item cmd);
            logic [7:0]  next_lvl;
            logic [15:0] t;
            logic [15:0] p;
            bit          settled;
            bit          phase;
            t_out_item   snap;
            phase = 1'b0;
            case (cmd.func)
                FUNC_LOAD: begin
                    if (cmd.level != 0) begin
                        level_tbl[cmd.level][cmd.channel] = cmd.table_value;
                        written[cmd.level][cmd.channel] = 1'b1;
                        loads++;
                    end
                end
                FUNC_SET_LEVEL: begin
                    reached = cmd.level;
                    goal = cmd.level;
                    if (cmd.level == 0) begin
                        for (int c = 0; c < 4; c++) begin
                            pwm[c] = '0;
                        end
                        enable = 1'b0;
                    end else begin
                        for (int c = 0; c < 4; c++) begin
                            pwm[c] = level_pwm(cmd.level, c);
                        end
                        enable = in_band(cmd.level);
                        phase = !was_on;
                    end
                    was_on = (cmd.level != 0);
                    set_levels++;
                    if (phase) begin
                        phase_restarts++;
                    end
                end
                FUNC_SET_GOAL: begin
                    goal = cmd.level;
                    goals++;
                end
                default: begin
                    next_lvl = goal;
                    if (goal < reached) begin
                        next_lvl = reached - 8'd1;
                    end else if (goal > reached) begin
                        next_lvl = reached + 8'd1;
                    end
                    enable = in_band(next_lvl);
                    settled = 1'b1;
                    for (int c = 0; c < 4; c++) begin
                        t = level_pwm(next_lvl, c);
                        p = pwm[c];
                        if (c == 0 && next_lvl <= reached && p == 0 && t == full_on) begin
                            p = t;
                            if (t != 0) begin
                                ch0_snaps++;
                            end
                        end else if (p < t) begin
                            p = p + 16'd1;
                        end else if (p > t) begin
                            p = p - 16'd1;
                        end
                        pwm[c] = p;
                        if (p != t) begin
                            settled = 1'b0;
                        end
                    end
                    if (settled) begin
                        if (reached != next_lvl) begin
                            level_steps++;
                        end
                        reached = next_lvl;
                    end
                    ticks++;
                end
            endcase
            snap.pwm_ch0 = pwm[0];
            snap.pwm_ch1 = pwm[1];
            snap.pwm_ch2 = pwm[2];
            snap.pwm_ch3 = pwm[3];
            snap.current_level = reached;
            snap.power_enable = enable;
            snap.phase_reset = phase;
            expected_snapshots.push_back(snap);
        endfunction

        function void flag(string what, t_out_item want, t_out_item got);
            errors++;
            if (errors <= 10) begin
                $display("%0t %s: expected pwm %h %h %h %h lvl %0d en %b ph %b",
                         $time, what, want.pwm_ch0, want.pwm_ch1, want.pwm_ch2,
                         want.pwm_ch3, want.current_level, want.power_enable,
                         want.phase_reset);
                $display("    got pwm %h %h %h %h lvl %0d en %b ph %b",
                         got.pwm_ch0, got.pwm_ch1, got.pwm_ch2, got.pwm_ch3,
                         got.current_level, got.power_enable, got.phase_reset);
            end
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (expected_snapshots.size() == 0) begin
                flag("unexpected output transfer", '0, got);
                return;
            end
            want = expected_snapshots.pop_front();
            checked++;
            if (got.pwm_ch0 !== want.pwm_ch0 || got.pwm_ch1 !== want.pwm_ch1 ||
                got.pwm_ch2 !== want.pwm_ch2 || got.pwm_ch3 !== want.pwm_ch3 ||
                got.current_level !== want.current_level ||
                got.power_enable !== want.power_enable ||
                got.phase_reset !== want.phase_reset) begin
                flag("output mismatch", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    wire         in_ready;
    t_in_item    in_item = '0;
    wire         out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    slew_predictor ramp = new();
    int          burst_left = 0;
    int          commands_sent = 0;
    int          quiet_cycles = 0;
    logic [15:0] ready_pat = 16'hFFFF;
    logic [7:0]  pat_timer = '0;

    led_ramp_level_slewer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            ramp.check_output(out_item);
        end
        pat_timer <= pat_timer + 8'd1;
        if (pat_timer == 0) begin
            ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end else begin
            ready_pat <= {ready_pat[0], ready_pat[15:1]};
        end
        out_ready <= ready_pat[0];
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_CYCLES) begin
                $display("tb_led_ramp_level_slewer: FAIL");
                $finish;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] func, input logic [7:0] lv,
                            input logic [1:0] ch, input logic [15:0] value);
        t_in_item cmd;
        int       gap;
        cmd.func = func;
        cmd.level = lv;
        cmd.channel = ch;
        cmd.table_value = value;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_item <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ramp.apply_command(cmd);
        if (!(func == FUNC_LOAD && lv == 0)) begin
            commands_sent++;
        end
    endtask

    task automatic tick_run(input int n);
        for (int i = 0; i < n; i++) begin
            send_cmd(FUNC_TICK, 8'($urandom), 2'($urandom), 16'($urandom));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ramp.expected_snapshots.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ramp.write_reg(idx, data);
    endtask

    task automatic apply_settings(input int ph);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] fo;
        case (ph)
            0: begin lo = 8'd1; hi = 8'd255; fo = 16'd255; end
            1: begin lo = 8'd0; hi = 8'd0; fo = 16'd0; end
            2: begin lo = 8'd200; hi = 8'd10; fo = 16'hFFFF; end
            3: begin
                lo = 8'($urandom_range(0, 60));
                hi = 8'($urandom_range(100, 255));
                fo = 16'($urandom_range(1, 12));
            end
            default: begin lo = 8'd255; hi = 8'd255; fo = 16'd6; end
        endcase
        write_reg(CFG_EN_LOW, {8'd0, lo});
        write_reg(CFG_EN_HIGH, {8'd0, hi});
        write_reg(CFG_FULL_ON, fo);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] table_entry_value(int ch);
        int r;
        r = $urandom_range(0, 39);
        if (r < ((ch == 0) ? 8 : 2)) begin
            return ramp.full_on;
        end else if (r == 10) begin
            return 16'($urandom);
        end else if (r >= 11 && r <= 14) begin
            return 16'd0;
        end
        return 16'($urandom_range(0, 8));
    endfunction

    task automatic ready_span(output int lo, output int hi);
        lo = ramp.reached;
        while (lo > 0 && ramp.level_ready(lo - 1)) lo--;
        hi = ramp.reached;
        while (hi < 255 && ramp.level_ready(hi + 1)) hi++;
    endtask

    task automatic run_random(input int quota);
        int start, lo, hi, base, cnt, lv, tries;
        bit paused;
        start = commands_sent;
        paused = 1'b0;
        while (commands_sent - start < quota) begin
            if (!paused && commands_sent - start >= quota / 2) begin
                drain();
                paused = 1'b1;
            end
            ready_span(lo, hi);
            case ($urandom_range(0, 9))
                0, 1: begin
                    case ($urandom_range(0, 3))
                        0, 1: base = (hi < 255) ? hi + 1 : $urandom_range(1, 255);
                        2: base = $urandom_range(1, 255);
                        default: base = (lo > 1) ? lo - 1 : ((ramp.reached == 0) ? 1 : ramp.reached);
                    endcase
                    cnt = $urandom_range(1, 4);
                    for (int l = base; l < base + cnt && l <= 255; l++) begin
                        for (int ch = 0; ch < 4; ch++) begin
                            send_cmd(FUNC_LOAD, 8'(l), 2'(ch), table_entry_value(ch));
                        end
                    end
                end
                2: send_cmd(FUNC_LOAD, 8'd0, 2'($urandom), 16'($urandom));
                3, 4: begin
                    lv = 0;
                    if ($urandom_range(0, 4) != 0) begin
                        for (tries = 0; tries < 20 && lv == 0; tries++) begin
                            base = $urandom_range(1, 255);
                            if (ramp.level_ready(base)) begin
                                lv = base;
                            end
                        end
                    end
                    send_cmd(FUNC_SET_LEVEL, 8'(lv), 2'($urandom), 16'($urandom));
                    tick_run($urandom_range(0, 6));
                end
                5, 6, 7, 8: begin
                    lv = $urandom_range(lo, hi);
                    send_cmd(FUNC_SET_GOAL, 8'(lv), 2'($urandom), 16'($urandom));
                    tick_run($urandom_range(1, 30));
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        tick_run(1);
                    end else begin
                        send_cmd(FUNC_SET_GOAL, ramp.reached, 2'($urandom), 16'($urandom));
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_settings(0);

        send_cmd(FUNC_LOAD, 8'd1, 2'd0, 16'd255);
        send_cmd(FUNC_LOAD, 8'd1, 2'd1, 16'd1);
        send_cmd(FUNC_LOAD, 8'd1, 2'd2, 16'd2);
        send_cmd(FUNC_LOAD, 8'd1, 2'd3, 16'd0);
        send_cmd(FUNC_LOAD, 8'd2, 2'd0, 16'd0);
        send_cmd(FUNC_LOAD, 8'd2, 2'd1, 16'd2);
        send_cmd(FUNC_LOAD, 8'd2, 2'd2, 16'd1);
        send_cmd(FUNC_LOAD, 8'd2, 2'd3, 16'd3);
        for (int ch = 0; ch < 4; ch++) begin
            send_cmd(FUNC_LOAD, 8'd255, 2'(ch), 16'hFFFF);
        end
        send_cmd(FUNC_LOAD, 8'd0, 2'd3, 16'hFFFF);
        send_cmd(FUNC_SET_LEVEL, 8'd255, 2'd0, 16'd0);
        send_cmd(FUNC_SET_LEVEL, 8'd2, 2'd0, 16'd0);
        send_cmd(FUNC_SET_LEVEL, 8'd0, 2'd0, 16'd0);
        send_cmd(FUNC_SET_LEVEL, 8'd2, 2'd0, 16'd0);
        send_cmd(FUNC_SET_GOAL, 8'd1, 2'd0, 16'd0);
        tick_run(4);
        send_cmd(FUNC_SET_GOAL, 8'd0, 2'd0, 16'd0);
        tick_run(2);
        send_cmd(FUNC_SET_LEVEL, 8'd0, 2'd0, 16'd0);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) begin
                drain();
                apply_settings(ph);
            end
            run_random(PHASE_COMMANDS);
        end
        drain();

        $display("Covered %0d table loads, %0d level jumps, %0d goal changes and %0d ticks",
                 ramp.loads, ramp.set_levels, ramp.goals, ramp.ticks);
        $display("over five register settings; %0d results checked, %0d channel-zero snaps, %0d phase restarts, %0d level steps, %0d mismatches.",
                 ramp.checked, ramp.ch0_snaps, ramp.phase_restarts, ramp.level_steps,
                 ramp.errors);
        if (ramp.errors == 0 && ramp.expected_snapshots.size() == 0) begin
            $display("tb_led_ramp_level_slewer: PASS");
        end else begin
            $display("tb_led_ramp_level_slewer: FAIL");
        end
        $finish;
    end

endmodule
